/* rtl/float_sine_cosine_unit_macros.svh */
// Assertion macros for the float sine/cosine unit.
// Used by the top level; expects signals named clk and rst in scope.
`ifndef FLOAT_SINE_COSINE_UNIT_MACROS_SVH
`define FLOAT_SINE_COSINE_UNIT_MACROS_SVH

// Flag a condition that must never hold out of reset.
`define FSCU_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Flag a consequence that must follow in the cycle after its trigger.
`define FSCU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/fscu_pkg.sv */
// Shared types, constants and IEEE single-precision arithmetic helpers
// for the float sine/cosine unit. No dependencies.
`timescale 1ns / 1ps

package fscu_pkg;

  typedef struct packed {
    logic        command;
    logic [31:0] operand;
  } op_t;

  typedef struct packed {
    logic [31:0] value;
    logic        range_error;
  } res_t;

  typedef struct packed {
    logic [31:0] r;
    logic [31:0] r2;
    logic        use_cos;
    logic        negate;
    logic        err;
  } red_t;

  localparam int QueueDepth = 16;

  localparam logic CmdSine   = 1'b0;
  localparam logic CmdCosine = 1'b1;

  localparam logic [31:0] TwoOverPi = 32'h3F22F983;
  localparam logic [31:0] HalfPi    = 32'h3FC90FDB;
  localparam logic [31:0] S3        = 32'hBE2AAAAB;
  localparam logic [31:0] S5        = 32'h3C088889;
  localparam logic [31:0] S7        = 32'hB9500D01;
  localparam logic [31:0] C2        = 32'hBF000000;
  localparam logic [31:0] C4        = 32'h3D2AAAAB;
  localparam logic [31:0] C6        = 32'hBAB60B61;
  localparam logic [31:0] PosHalf   = 32'h3F000000;
  localparam logic [31:0] NegHalf   = 32'hBF000000;
  localparam logic [31:0] One       = 32'h3F800000;
  localparam logic [31:0] SignBit   = 32'h80000000;

  function automatic logic [5:0] lzc50(input logic [49:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd50;
    found = 1'b0;
    for (int i = 49; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 6'(49 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // m has its leading one at bit 49, which carries biased exponent e
  function automatic logic [31:0] round_pack(input logic s, input logic signed [10:0] e,
                                             input logic [49:0] m);
    logic [49:0] sh;
    logic [10:0] amt;
    logic [22:0] fr;
    logic        g;
    logic        st;
    logic [7:0]  ef;
    logic [31:0] res;
    if (m == 50'd0) return {s, 31'd0};
    if (e >= 11'sd255) return {s, 8'hFF, 23'd0};
    if (e >= 11'sd1) begin
      sh = m;
      ef = e[7:0];
    end else begin
      amt = 11'(11'sd1 - e);
      if (amt >= 11'd50) begin
        sh = {49'd0, 1'b1};
      end else begin
        sh = (m >> amt) | {49'd0, |(m & ~({50{1'b1}} << amt))};
      end
      ef = 8'd0;
    end
    fr = sh[48:26];
    g = sh[25];
    st = |sh[24:0];
    res = {s, ef, fr};
    if (g && (st || fr[0])) res = res + 32'd1;
    return res;
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic        s;
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [23:0] ma;
    logic [23:0] mb;
    logic [47:0] p;
    logic [5:0]  lz;
    logic [49:0] m;
    logic signed [10:0] e;
    s = a[31] ^ b[31];
    ea = a[30:23];
    eb = b[30:23];
    if (ea == 8'hFF || eb == 8'hFF) return {s, 8'hFF, 23'd0};
    ma = {|ea, a[22:0]};
    mb = {|eb, b[22:0]};
    p = ma * mb;
    if (p == 48'd0) return {s, 31'd0};
    lz = lzc50({p, 2'b00});
    m = {p, 2'b00} << lz;
    e = 11'($signed({3'd0, (ea == 8'd0) ? 8'd1 : ea}) + $signed({3'd0, (eb == 8'd0) ? 8'd1 : eb})
        - 11'sd126 - $signed({5'd0, lz}));
    return round_pack(s, e, m);
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] big;
    logic [31:0] sml;
    logic [7:0]  eae;
    logic [7:0]  ebe;
    logic [7:0]  d;
    logic [49:0] ax;
    logic [49:0] bf;
    logic [49:0] bx;
    logic [49:0] sum;
    logic [5:0]  lz;
    logic [49:0] m;
    logic signed [10:0] e;
    if (a[30:23] == 8'hFF) return a;
    if (b[30:23] == 8'hFF) return b;
    if (b[30:0] > a[30:0]) begin
      big = b;
      sml = a;
    end else begin
      big = a;
      sml = b;
    end
    if (sml[30:0] == 31'd0) begin
      if (big[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
      return big;
    end
    eae = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    ebe = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d = eae - ebe;
    ax = {1'b0, |big[30:23], big[22:0], 25'd0};
    bf = {1'b0, |sml[30:23], sml[22:0], 25'd0};
    if (d >= 8'd50) begin
      bx = {49'd0, 1'b1};
    end else begin
      bx = (bf >> d) | {49'd0, |(bf & ~({50{1'b1}} << d))};
    end
    sum = (big[31] == sml[31]) ? ax + bx : ax - bx;
    if (sum == 50'd0) return 32'd0;
    lz = lzc50(sum);
    m = sum << lz;
    e = 11'($signed({3'd0, eae}) + 11'sd1 - $signed({5'd0, lz}));
    return round_pack(big[31], e, m);
  endfunction

  // truncate toward zero; top bit flags a result outside signed 32 bits
  function automatic logic [32:0] fp_to_int(input logic [31:0] t);
    logic        s;
    logic [7:0]  e;
    logic        err;
    logic [55:0] sh;
    logic [31:0] mag;
    s = t[31];
    e = t[30:23];
    err = (e > 8'd158) || (e == 8'd158 && (!s || t[22:0] != 23'd0));
    if (e < 8'd127) begin
      mag = 32'd0;
    end else begin
      sh = {32'd0, 1'b1, t[22:0]} << (e - 8'd127);
      mag = sh[54:23];
    end
    return {err, s ? 32'(-mag) : mag};
  endfunction

  function automatic logic [31:0] int_to_fp(input logic [31:0] n);
    logic        s;
    logic [31:0] mag;
    logic [5:0]  lz;
    logic [49:0] m;
    logic signed [10:0] e;
    s = n[31];
    mag = s ? 32'(-n) : n;
    if (mag == 32'd0) return 32'd0;
    lz = lzc50({mag, 18'd0});
    m = {mag, 18'd0} << lz;
    e = 11'(11'sd158 - $signed({5'd0, lz}));
    return round_pack(s, e, m);
  endfunction

endpackage

/* rtl/fscu_queue.sv */
// Small synchronous queue after each pipeline section of the sine/cosine unit.
// Standalone; width and depth come from the instantiating module.
`timescale 1ns / 1ps

module fscu_queue #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [Width-1:0] wdata,
  input  logic             pop,
  output logic [Width-1:0] rdata,
  output logic             empty
);

  localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountW = $clog2(Depth + 1);

  logic [Width-1:0]  mem [Depth];
  logic [AddrW-1:0]  wr_ptr;
  logic [AddrW-1:0]  rd_ptr;
  logic [CountW-1:0] count;

  logic do_pop;

  assign empty  = (count == '0);
  assign do_pop = pop && !empty;
  assign rdata  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AddrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AddrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/fscu_front.sv */
// Front section: classify the argument, find the quadrant and reduce it.
// Seven stages, one float operation each. Depends on fscu_pkg.
`timescale 1ns / 1ps

module fscu_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  fscu_pkg::op_t  op,
  output logic           out_valid,
  output fscu_pkg::red_t red
);

  typedef struct packed {
    logic        cmd;
    logic [31:0] x;
    logic        err;
    logic        use_cos;
    logic        negate;
    logic [31:0] n;
    logic [31:0] acc;
  } fstage_t;

  localparam int Stages = 7;

  fstage_t    st [1:Stages];
  fstage_t    st_next [1:Stages];
  logic [Stages:1] vld;

  logic [32:0] conv;
  logic [1:0]  k;
  logic        use_cos_next;
  logic        negate_next;
  logic [31:0] offset;

  assign offset = (st[1].x[31] && st[1].x[30:0] != 31'd0) ? fscu_pkg::NegHalf
                                                          : fscu_pkg::PosHalf;
  assign conv = fscu_pkg::fp_to_int(st[2].acc);
  assign k    = conv[1:0];

  always_comb begin
    if (st[2].cmd == fscu_pkg::CmdSine) begin
      use_cos_next = k[0];
      negate_next  = k[1];
    end else begin
      use_cos_next = !k[0];
      negate_next  = k[1] ^ k[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[Stages-1:1], in_valid};
    end
  end

  always_comb begin
    st_next[1].cmd     = op.command;
    st_next[1].x       = op.operand;
    st_next[1].err     = &op.operand[30:23];
    st_next[1].use_cos = 1'b0;
    st_next[1].negate  = 1'b0;
    st_next[1].n       = '0;
    st_next[1].acc     = fscu_pkg::fp_mul(op.operand, fscu_pkg::TwoOverPi);

    st_next[2]     = st[1];
    st_next[2].acc = fscu_pkg::fp_add(st[1].acc, offset);

    st_next[3]         = st[2];
    st_next[3].err     = st[2].err | conv[32];
    st_next[3].n       = conv[31:0];
    st_next[3].use_cos = use_cos_next;
    st_next[3].negate  = negate_next;

    st_next[4]     = st[3];
    st_next[4].acc = fscu_pkg::int_to_fp(st[3].n);

    st_next[5]     = st[4];
    st_next[5].acc = fscu_pkg::fp_mul(st[4].acc, fscu_pkg::HalfPi);

    st_next[6]     = st[5];
    st_next[6].acc = fscu_pkg::fp_add(st[5].x, st[5].acc ^ fscu_pkg::SignBit);

    st_next[7]     = st[6];
    st_next[7].n   = st[6].acc;
    st_next[7].acc = fscu_pkg::fp_mul(st[6].acc, st[6].acc);
  end

  always_ff @(posedge clk) begin
    for (int i = 1; i <= Stages; i++) begin
      st[i] <= st_next[i];
    end
  end

  assign out_valid   = vld[Stages];
  assign red.r       = st[Stages].n;
  assign red.r2      = st[Stages].acc;
  assign red.use_cos = st[Stages].use_cos;
  assign red.negate  = st[Stages].negate;
  assign red.err     = st[Stages].err;

endmodule

/* rtl/fscu_back.sv */
// Back section: Horner kernel for sine or cosine, sign fix and flagging.
// Seven stages, at most one float operation each. Depends on fscu_pkg.
`timescale 1ns / 1ps

module fscu_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  fscu_pkg::red_t red,
  output logic           out_valid,
  output fscu_pkg::res_t result
);

  typedef struct packed {
    fscu_pkg::red_t ctl;
    logic [31:0]    acc;
  } bstage_t;

  localparam int Stages = 7;

  bstage_t         st [1:Stages];
  logic [Stages:1] vld;

  logic [31:0] res;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[Stages-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    st[1].ctl <= red;
    st[1].acc <= fscu_pkg::fp_mul(red.r2, red.use_cos ? fscu_pkg::C6 : fscu_pkg::S7);

    st[2].ctl <= st[1].ctl;
    st[2].acc <= fscu_pkg::fp_add(st[1].ctl.use_cos ? fscu_pkg::C4 : fscu_pkg::S5, st[1].acc);

    st[3].ctl <= st[2].ctl;
    st[3].acc <= fscu_pkg::fp_mul(st[2].ctl.r2, st[2].acc);

    st[4].ctl <= st[3].ctl;
    st[4].acc <= fscu_pkg::fp_add(st[3].ctl.use_cos ? fscu_pkg::C2 : fscu_pkg::S3, st[3].acc);

    st[5].ctl <= st[4].ctl;
    st[5].acc <= fscu_pkg::fp_mul(st[4].ctl.r2, st[4].acc);

    st[6].ctl <= st[5].ctl;
    st[6].acc <= fscu_pkg::fp_add(fscu_pkg::One, st[5].acc);

    st[7].ctl <= st[6].ctl;
    st[7].acc <= st[6].ctl.use_cos ? st[6].acc : fscu_pkg::fp_mul(st[6].ctl.r, st[6].acc);
  end

  assign res = st[Stages].acc ^ (st[Stages].ctl.negate ? fscu_pkg::SignBit : 32'd0);

  assign out_valid          = vld[Stages];
  assign result.value       = st[Stages].ctl.err ? 32'd0 : res;
  assign result.range_error = st[Stages].ctl.err;

endmodule

/* rtl/float_sine_cosine_unit.sv */
// Top level of the float sine/cosine unit: front section, queues, back section.
// Depends on fscu_pkg, fscu_queue, fscu_front, fscu_back and the macro header.
`timescale 1ns / 1ps

`include "float_sine_cosine_unit_macros.svh"

// Single-precision sine or cosine, one request per cycle sustained while full
// stays low. A request passes through the reduction pipeline, the middle queue,
// the polynomial pipeline and the result queue, from whose head it is popped.
// Each pipeline stage holds at most one rounded float operation. full rises
// once the front pipeline plus middle queue hold MidDepth requests; the back
// pipeline only starts a request when the result queue has room for it, so
// stalls on pop back up through both queues. Non-finite arguments and
// arguments whose quadrant index leaves signed 32 bits return zero with
// range_error set.
module float_sine_cosine_unit #(
  parameter int MidDepth = fscu_pkg::QueueDepth,
  parameter int OutDepth = fscu_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  fscu_pkg::op_t  operation,
  output logic           empty,
  input  logic           pop,
  output fscu_pkg::res_t result
);

  localparam int MidCountW = $clog2(MidDepth + 1);
  localparam int OutCountW = $clog2(OutDepth + 1);

  logic [MidCountW-1:0] front_count;
  logic [OutCountW-1:0] back_count;

  logic           accept;
  logic           issue;
  logic           drain;
  logic           front_valid;
  fscu_pkg::red_t front_red;
  logic           mid_empty;
  fscu_pkg::red_t mid_head;
  logic           back_valid;
  fscu_pkg::res_t back_res;

  assign full   = (front_count == MidCountW'(MidDepth));
  assign accept = push && !full;
  assign issue  = !mid_empty && (back_count != OutCountW'(OutDepth));
  assign drain  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_count <= '0;
      back_count  <= '0;
    end else begin
      if (accept && !issue) begin
        front_count <= front_count + 1'b1;
      end else if (!accept && issue) begin
        front_count <= front_count - 1'b1;
      end
      if (issue && !drain) begin
        back_count <= back_count + 1'b1;
      end else if (!issue && drain) begin
        back_count <= back_count - 1'b1;
      end
    end
  end

  fscu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .op        (operation),
    .out_valid (front_valid),
    .red       (front_red)
  );

  fscu_queue #(
    .Width ($bits(fscu_pkg::red_t)),
    .Depth (MidDepth)
  ) u_mid_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (front_valid),
    .wdata (front_red),
    .pop   (issue),
    .rdata (mid_head),
    .empty (mid_empty)
  );

  fscu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (issue),
    .red       (mid_head),
    .out_valid (back_valid),
    .result    (back_res)
  );

  fscu_queue #(
    .Width ($bits(fscu_pkg::res_t)),
    .Depth (OutDepth)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (back_valid),
    .wdata (back_res),
    .pop   (drain),
    .rdata (result),
    .empty (empty)
  );

  `FSCU_ASSERT_NEVER(a_front_bound, front_count > MidCountW'(MidDepth), "front credit overrun")
  `FSCU_ASSERT_NEVER(a_back_bound, back_count > OutCountW'(OutDepth), "back credit overrun")
  `FSCU_ASSERT_NEXT(a_front_grow, accept && !issue, front_count == $past(front_count) + 1'b1, "front credit lost")
  `FSCU_ASSERT_NEVER(a_issue_room, issue && back_count == OutCountW'(OutDepth), "issue without room")

endmodule

/* sim/fscu_checker.sv */
// Scoreboard for the float sine/cosine unit: predicts each result from its request
// with its own bit-exact single-precision arithmetic and compares. Depends on fscu_pkg.
`timescale 1ns / 1ps

module fscu_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  logic           full,
  input  fscu_pkg::op_t  operation,
  input  logic           empty,
  input  logic           pop,
  input  fscu_pkg::res_t result,
  output int             errors,
  output int             pending
);

  fscu_pkg::res_t expected_results[$];

  function automatic logic [31:0] sp_round(input logic s, input int e2,
                                           input logic [127:0] mag);
    int p;
    int sh;
    int eb;
    logic [127:0] kept;
    logic g;
    logic st;
    longint v;
    if (mag == 0) return {s, 31'd0};
    p = 127;
    while (!mag[p]) p--;
    if (p + e2 + 127 >= 1) begin
      sh = p - 23;
      eb = p + e2 + 126;
    end else begin
      sh = -149 - e2;
      eb = 0;
    end
    if (sh > 128) begin
      kept = 0;
      g = 1'b0;
      st = 1'b1;
    end else if (sh > 0) begin
      kept = mag >> sh;
      g = mag[sh-1];
      st = (sh > 1) ? |(mag & ((128'd1 << (sh - 1)) - 1)) : 1'b0;
    end else begin
      kept = mag << (-sh);
      g = 1'b0;
      st = 1'b0;
    end
    v = (longint'(eb) << 23) + longint'(kept[31:0]);
    if (g && (st || kept[0])) v = v + 1;
    if (v >= 64'h7F800000) return {s, 8'hFF, 23'd0};
    return {s, v[30:0]};
  endfunction

  function automatic logic [23:0] sig_of(input logic [31:0] a);
    return {|a[30:23], a[22:0]};
  endfunction

  function automatic int exp_of(input logic [31:0] a);
    return ((a[30:23] == 8'd0) ? 1 : int'(a[30:23])) - 150;
  endfunction

  function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
    logic [127:0] m;
    m = 128'(sig_of(a)) * 128'(sig_of(b));
    return sp_round(a[31] ^ b[31], exp_of(a) + exp_of(b), m);
  endfunction

  function automatic logic [31:0] sp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] hi;
    logic [31:0] lo;
    logic [127:0] am;
    logic [127:0] bm;
    logic [127:0] sum;
    int d;
    if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
    if (b[30:0] > a[30:0]) begin
      hi = b;
      lo = a;
    end else begin
      hi = a;
      lo = b;
    end
    d = exp_of(hi) - exp_of(lo);
    am = 128'(sig_of(hi)) << 40;
    bm = 128'(sig_of(lo)) << 40;
    if (d >= 64) begin
      bm = 128'(bm != 0);
    end else if (d > 0) begin
      bm = (bm >> d) | 128'((bm & ((128'd1 << d) - 1)) != 0);
    end
    sum = (hi[31] == lo[31]) ? am + bm : am - bm;
    if (sum == 0) return 32'd0;
    return sp_round(hi[31], exp_of(hi) - 40, sum);
  endfunction

  function automatic logic [31:0] sine_kernel(input logic [31:0] r);
    logic [31:0] r2;
    logic [31:0] p;
    r2 = sp_mul(r, r);
    p = sp_add(fscu_pkg::S5, sp_mul(r2, fscu_pkg::S7));
    p = sp_add(fscu_pkg::S3, sp_mul(r2, p));
    p = sp_add(fscu_pkg::One, sp_mul(r2, p));
    return sp_mul(r, p);
  endfunction

  function automatic logic [31:0] cosine_kernel(input logic [31:0] r);
    logic [31:0] r2;
    logic [31:0] p;
    r2 = sp_mul(r, r);
    p = sp_add(fscu_pkg::C4, sp_mul(r2, fscu_pkg::C6));
    p = sp_add(fscu_pkg::C2, sp_mul(r2, p));
    return sp_add(fscu_pkg::One, sp_mul(r2, p));
  endfunction

  function automatic fscu_pkg::res_t trig_value(input fscu_pkg::op_t o);
    fscu_pkg::res_t res;
    logic [31:0] x;
    logic [31:0] q;
    logic [31:0] t;
    logic [31:0] nf;
    logic [31:0] r;
    logic [31:0] v;
    logic [63:0] mag;
    logic [1:0] k;
    int te;
    logic use_cos;
    logic negate;
    res.value = 32'd0;
    res.range_error = 1'b1;
    x = o.operand;
    if (x[30:23] == 8'hFF) return res;
    q = sp_mul(x, fscu_pkg::TwoOverPi);
    t = sp_add(q, (!x[31] || x[30:0] == 0) ? fscu_pkg::PosHalf : fscu_pkg::NegHalf);
    te = t[30:23];
    if (te > 158 || (te == 158 && (!t[31] || t[22:0] != 0))) return res;
    if (te < 127) mag = 0;
    else if (te >= 150) mag = {40'd0, 1'b1, t[22:0]} << (te - 150);
    else mag = {40'd0, 1'b1, t[22:0]} >> (150 - te);
    nf = sp_round(t[31] && mag != 0, 0, 128'(mag));
    r = sp_add(x, sp_mul(nf, fscu_pkg::HalfPi) ^ fscu_pkg::SignBit);
    k = t[31] ? 2'(-mag) : mag[1:0];
    if (o.command == fscu_pkg::CmdSine) begin
      use_cos = k[0];
      negate = k[1];
    end else begin
      use_cos = !k[0];
      negate = (k == 2'd1 || k == 2'd2);
    end
    v = use_cos ? cosine_kernel(r) : sine_kernel(r);
    res.value = negate ? v ^ fscu_pkg::SignBit : v;
    res.range_error = 1'b0;
    return res;
  endfunction

  always @(posedge clk) begin
    fscu_pkg::res_t want;
    if (rst) begin
      errors <= 0;
      pending <= 0;
    end else begin
      if (push && !full) expected_results.push_back(trig_value(operation));
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h/%b", $time, result.value,
                   result.range_error);
          errors <= errors + 1;
        end else begin
          want = expected_results.pop_front();
          if (want.value !== result.value || want.range_error !== result.range_error) begin
            $display("%0t: mismatch expected %h/%b actual %h/%b", $time, want.value,
                     want.range_error, result.value, result.range_error);
            errors <= errors + 1;
          end
        end
      end
      pending <= expected_results.size();
    end
  end

endmodule

/* sim/tb_float_sine_cosine_unit.sv */
// Testbench top for float_sine_cosine_unit: clock, reset, request and pop stimulus
// with random gaps and a long pop hold-off. Depends on it, fscu_pkg and fscu_checker.
`timescale 1ns / 1ps

module tb_float_sine_cosine_unit;

  logic           clk;
  logic           rst;
  logic           push;
  logic           full;
  fscu_pkg::op_t  operation;
  logic           empty;
  logic           pop;
  fscu_pkg::res_t result;
  int   errors;
  int   pending;
  int   item_count;
  int   pop_count;
  int   idle_cycles;

  float_sine_cosine_unit uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .operation(operation),
    .empty(empty), .pop(pop), .result(result)
  );

  fscu_checker scoreboard (
    .clk(clk), .rst(rst), .push(push), .full(full), .operation(operation),
    .empty(empty), .pop(pop), .result(result), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int draw_gap(input int n);
    return ((n / 80) % 3 == 0) ? 0 : $urandom_range(0, 8);
  endfunction

  task automatic send_request(input logic cmd, input logic [31:0] x);
    int gap;
    gap = draw_gap(item_count);
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push <= 1'b1;
    operation <= '{command: cmd, operand: x};
    do @(posedge clk); while (full);
    item_count++;
  endtask

  function automatic logic [31:0] random_operand();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return {1'($urandom), 8'($urandom_range(100, 140)), 23'($urandom)};
    if (pick < 8) return $urandom;
    return {1'($urandom), 8'($urandom_range(155, 158)), 23'($urandom)};
  endfunction

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 5000) begin
        $display("float_sine_cosine_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int gap;
    pop = 1'b0;
    pop_count = 0;
    @(negedge rst);
    forever begin
      gap = draw_gap(pop_count);
      if (pop_count == 300) gap = 200;
      repeat (gap) begin
        @(negedge clk);
        pop <= 1'b0;
      end
      @(negedge clk);
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      pop_count++;
    end
  end

  initial begin
    logic [31:0] corner[$];
    rst = 1'b1;
    push = 1'b0;
    operation = '0;
    item_count = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    corner = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000, 32'h7FC00000,
               32'hFFFFFFFF, 32'h7F800001, 32'h7F7FFFFF, 32'hFF7FFFFF, 32'h00000001,
               32'h80000001, 32'h3F800000, 32'hBFC90FDB, 32'h40490FDB, 32'h4F48FFFF,
               32'h4F490FDB, 32'hCF490FDB, 32'hCF48FFFF, 32'h3F490FDB, 32'hC0490FDB};
    foreach (corner[i]) begin
      send_request(fscu_pkg::CmdSine, corner[i]);
      if (i < 5) send_request(fscu_pkg::CmdCosine, corner[i]);
    end
    repeat (1050) send_request(1'($urandom), random_operand());
    @(negedge clk);
    push <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("float_sine_cosine_unit regression: pass");
    end else begin
      $display("float_sine_cosine_unit regression: fail");
    end
    $finish;
  end

endmodule
